[hdl/mmst_pkg.sv]
// Shared widths, codes and reset values for the multi-mode software timer.
`timescale 1ns / 1ps

package mmst_pkg;

  localparam int unsigned ElapsedW = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_PERIODIC  = 3'd0,
    MODE_TOGGLE    = 3'd1,
    MODE_COUNT_UP  = 3'd2,
    MODE_COUNT_DN  = 3'd3,
    MODE_ON_DELAY  = 3'd4,
    MODE_OFF_DELAY = 3'd5
  } timer_mode_e;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK    = 2'd0,
    ACT_BEGIN   = 2'd1,
    ACT_RESTART = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMER_MODE  = 2'd0,
    CFG_PERIOD_MS   = 2'd1,
    CFG_COUNT_LIMIT = 2'd2
  } cfg_index_e;

  localparam logic [ModeW-1:0]    ModeReset   = MODE_PERIODIC;
  localparam logic [ElapsedW-1:0] PeriodReset = ElapsedW'(1000);
  localparam logic [CountW-1:0]   LimitReset  = '0;
  localparam logic [ElapsedW-1:0] ElapsedMax  = '1;

  typedef struct packed {
    logic                period_pulse;
    logic                toggle_level;
    logic                toggle_changed;
    logic                count_valid;
    logic [CountW-1:0]   count_value;
    logic                count_done;
    logic                delay_done;
    logic                done_trigger_level;
    logic [ElapsedW-1:0] elapsed_ms;
  } result_t;

endpackage

[hdl/multi_mode_software_timer_core.sv]
// Top level of the multi-mode software timer: input register, mode logic, result register.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | to core   | in_valid_i / in_ready_o  | action_i, delay_trigger_i
//  out     | from core | out_valid_o / out_ready_i| mode flags, count_value_o, elapsed_ms_o
//  cfg     | to core   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An item is evaluated while it sits in the input register, so its result is loaded into
// the result register; one item is taken in every cycle unless a held result stalls it.
// The single evaluation stage with its 32-bit increment and compare sets this rate.
// Reset stops the timer until a begin item and clears elapsed count, counter and toggle.
// A held result that is not taken stalls evaluation of the next item; the input then waits.

module multi_mode_software_timer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mmst_pkg::ActionW-1:0]     action_i,
  input  logic                             delay_trigger_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             period_pulse_o,
  output logic                             toggle_level_o,
  output logic                             toggle_changed_o,
  output logic                             count_valid_o,
  output logic [mmst_pkg::CountW-1:0]      count_value_o,
  output logic                             count_done_o,
  output logic                             delay_done_o,
  output logic                             done_trigger_level_o,
  output logic [mmst_pkg::ElapsedW-1:0]    elapsed_ms_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mmst_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mmst_pkg::CfgDataW-1:0]    cfg_data_i
);
  import mmst_pkg::*;

  logic [ModeW-1:0]    mode_q;
  logic [ElapsedW-1:0] period_q;
  logic [CountW-1:0]   limit_q;

  logic                in_valid_q;
  logic [ActionW-1:0]  action_q;
  logic                trig_q;

  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic                stopped_q, stopped_d;
  logic [CountW-1:0]   counter_q, counter_d;
  logic                toggle_q, toggle_d;

  logic                out_valid_q;
  result_t             res_q, res_d;
  logic                res_new;

  logic                res_free;
  logic                proc;
  logic [ElapsedW-1:0] el_inc;
  logic [ElapsedW-1:0] el_delay;
  logic                delay_hold;

  assign res_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && res_free;
  assign in_ready_o = !in_valid_q || res_free;
  assign cfg_ready_o = 1'b1;

  assign el_inc     = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign delay_hold = (mode_q == MODE_ON_DELAY) ? !trig_q : trig_q;
  assign el_delay   = delay_hold ? '0 : el_inc;

  always_comb begin
    elapsed_d = elapsed_q;
    stopped_d = stopped_q;
    counter_d = counter_q;
    toggle_d  = toggle_q;
    res_new   = 1'b0;
    res_d     = '0;
    if (proc) begin
      case (action_q)
        ACT_BEGIN: begin
          stopped_d = 1'b0;
          if (mode_q == MODE_COUNT_UP) begin
            counter_d = '0;
          end else if (mode_q == MODE_COUNT_DN) begin
            counter_d = limit_q;
          end
        end
        ACT_RESTART: begin
          elapsed_d = '0;
        end
        ACT_TICK: begin
          elapsed_d = el_inc;
          if (!stopped_q) begin
            res_new = 1'b1;
            case (mode_q)
              MODE_PERIODIC: begin
                if (el_inc >= period_q) begin
                  elapsed_d          = '0;
                  res_d.period_pulse = 1'b1;
                end
              end
              MODE_TOGGLE: begin
                if (el_inc >= period_q) begin
                  elapsed_d            = '0;
                  toggle_d             = !toggle_q;
                  res_d.toggle_changed = 1'b1;
                end
              end
              MODE_COUNT_UP, MODE_COUNT_DN: begin
                if (el_inc >= period_q) begin
                  elapsed_d = '0;
                  if (mode_q == MODE_COUNT_DN && counter_q == '0) begin
                    counter_d        = limit_q;
                    stopped_d        = 1'b1;
                    res_d.count_done = 1'b1;
                  end else if (mode_q == MODE_COUNT_UP && counter_q == limit_q) begin
                    counter_d        = '0;
                    stopped_d        = 1'b1;
                    res_d.count_done = 1'b1;
                  end else begin
                    res_d.count_valid = 1'b1;
                    res_d.count_value = counter_q;
                    counter_d = (mode_q == MODE_COUNT_UP) ? counter_q + 1'b1
                                                          : counter_q - 1'b1;
                  end
                end
              end
              MODE_ON_DELAY, MODE_OFF_DELAY: begin
                elapsed_d = el_delay;
                if (el_delay >= period_q && !delay_hold) begin
                  res_d.delay_done         = 1'b1;
                  res_d.done_trigger_level = trig_q;
                  stopped_d                = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    res_d.toggle_level = toggle_d;
    res_d.elapsed_ms   = elapsed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeReset;
      period_q    <= PeriodReset;
      limit_q     <= LimitReset;
      in_valid_q  <= 1'b0;
      elapsed_q   <= '0;
      stopped_q   <= 1'b1;
      counter_q   <= '0;
      toggle_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TIMER_MODE:  mode_q   <= cfg_data_i[ModeW-1:0];
          CFG_PERIOD_MS:   period_q <= cfg_data_i[ElapsedW-1:0];
          CFG_COUNT_LIMIT: limit_q  <= cfg_data_i[CountW-1:0];
          default: begin
          end
        endcase
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      elapsed_q <= elapsed_d;
      stopped_q <= stopped_d;
      counter_q <= counter_d;
      toggle_q  <= toggle_d;
      if (proc && res_new) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      trig_q   <= delay_trigger_i;
    end
    if (proc && res_new) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign period_pulse_o       = res_q.period_pulse;
  assign toggle_level_o       = res_q.toggle_level;
  assign toggle_changed_o     = res_q.toggle_changed;
  assign count_valid_o        = res_q.count_valid;
  assign count_value_o        = res_q.count_value;
  assign count_done_o         = res_q.count_done;
  assign delay_done_o         = res_q.delay_done;
  assign done_trigger_level_o = res_q.done_trigger_level;
  assign elapsed_ms_o         = res_q.elapsed_ms;

endmodule

[tb/sv/multi_mode_software_timer_core_test.sv]
// Self-checking testbench for the multi-mode software timer core.
`timescale 1ns / 1ps

module multi_mode_software_timer_core_test;
  import mmst_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;
  localparam logic [ActionW-1:0] ActIgnored = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ActionW-1:0] action_i = ACT_TICK;
  logic delay_trigger_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic period_pulse_o;
  logic toggle_level_o;
  logic toggle_changed_o;
  logic count_valid_o;
  logic [CountW-1:0] count_value_o;
  logic count_done_o;
  logic delay_done_o;
  logic done_trigger_level_o;
  logic [ElapsedW-1:0] elapsed_ms_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_TIMER_MODE;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [ModeW-1:0] cfg_mode = ModeReset;
  logic [ElapsedW-1:0] cfg_period = PeriodReset;
  logic [CountW-1:0] cfg_limit = LimitReset;
  logic [ElapsedW-1:0] elapsed_reg = '0;
  logic timer_stopped = 1'b1;
  logic [CountW-1:0] count_reg = '0;
  logic toggle_reg = 1'b0;

  result_t due_results[$];
  result_t want;
  int error_count = 0;
  int quiet_cycles = 0;
  bit steady_run = 1'b0;

  multi_mode_software_timer_core uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .delay_trigger_i      (delay_trigger_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .period_pulse_o       (period_pulse_o),
    .toggle_level_o       (toggle_level_o),
    .toggle_changed_o     (toggle_changed_o),
    .count_valid_o        (count_valid_o),
    .count_value_o        (count_value_o),
    .count_done_o         (count_done_o),
    .delay_done_o         (delay_done_o),
    .done_trigger_level_o (done_trigger_level_o),
    .elapsed_ms_o         (elapsed_ms_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit advance_timer(logic [ActionW-1:0] act, logic trig,
                                       output result_t res);
    logic hold_level;
    res = '0;
    if (act == ACT_BEGIN) begin
      timer_stopped = 1'b0;
      if (cfg_mode == MODE_COUNT_UP) begin
        count_reg = '0;
      end else if (cfg_mode == MODE_COUNT_DN) begin
        count_reg = cfg_limit;
      end
      return 1'b0;
    end
    if (act == ACT_RESTART) begin
      elapsed_reg = '0;
      return 1'b0;
    end
    if (act != ACT_TICK) begin
      return 1'b0;
    end
    if (elapsed_reg != ElapsedMax) begin
      elapsed_reg = elapsed_reg + 1'b1;
    end
    if (timer_stopped) begin
      return 1'b0;
    end
    case (cfg_mode)
      MODE_PERIODIC: begin
        if (elapsed_reg >= cfg_period) begin
          elapsed_reg = '0;
          res.period_pulse = 1'b1;
        end
      end
      MODE_TOGGLE: begin
        if (elapsed_reg >= cfg_period) begin
          elapsed_reg = '0;
          toggle_reg = ~toggle_reg;
          res.toggle_changed = 1'b1;
        end
      end
      MODE_COUNT_UP, MODE_COUNT_DN: begin
        if (elapsed_reg >= cfg_period) begin
          elapsed_reg = '0;
          if ((cfg_mode == MODE_COUNT_DN && count_reg == '0) ||
              (cfg_mode == MODE_COUNT_UP && count_reg == cfg_limit)) begin
            count_reg = (cfg_mode == MODE_COUNT_DN) ? cfg_limit : '0;
            timer_stopped = 1'b1;
            res.count_done = 1'b1;
          end else begin
            res.count_valid = 1'b1;
            res.count_value = count_reg;
            count_reg = (cfg_mode == MODE_COUNT_UP) ? count_reg + 1'b1 : count_reg - 1'b1;
          end
        end
      end
      MODE_ON_DELAY, MODE_OFF_DELAY: begin
        hold_level = (cfg_mode == MODE_ON_DELAY);
        if (trig != hold_level) begin
          elapsed_reg = '0;
        end
        if (elapsed_reg >= cfg_period && trig == hold_level) begin
          res.delay_done = 1'b1;
          res.done_trigger_level = trig;
          timer_stopped = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.toggle_level = toggle_reg;
    res.elapsed_ms = elapsed_reg;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] expected_val,
                                      logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("result with no item waiting for it, elapsed_ms %0d", elapsed_ms_o);
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("period_pulse", 32'(want.period_pulse), 32'(period_pulse_o));
        check_field("toggle_level", 32'(want.toggle_level), 32'(toggle_level_o));
        check_field("toggle_changed", 32'(want.toggle_changed), 32'(toggle_changed_o));
        check_field("count_valid", 32'(want.count_valid), 32'(count_valid_o));
        check_field("count_value", 32'(want.count_value), 32'(count_value_o));
        check_field("count_done", 32'(want.count_done), 32'(count_done_o));
        check_field("delay_done", 32'(want.delay_done), 32'(delay_done_o));
        check_field("done_trigger_level", 32'(want.done_trigger_level),
                    32'(done_trigger_level_o));
        check_field("elapsed_ms", want.elapsed_ms, elapsed_ms_o);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("multi_mode_software_timer_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [ActionW-1:0] act, logic trig);
    result_t res;
    while (!steady_run && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    delay_trigger_i <= trig;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_timer(act, trig, res)) begin
      due_results.push_back(res);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Leaves the write valid high so that back-to-back writes need no gap.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TIMER_MODE: cfg_mode = data[ModeW-1:0];
      CFG_PERIOD_MS: cfg_period = data;
      CFG_COUNT_LIMIT: cfg_limit = data[CountW-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [ModeW-1:0] mode, logic [ElapsedW-1:0] period,
                            logic [CountW-1:0] limit);
    logic [CfgDataW-1:0] noise;
    noise = $urandom;
    write_register(CFG_TIMER_MODE, {noise[CfgDataW-1:ModeW], mode});
    write_register(CFG_PERIOD_MS, period);
    noise = $urandom;
    write_register(CFG_COUNT_LIMIT, {noise[CfgDataW-1:CountW], limit});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_stopped_after_reset();
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b1);
    send_item(ActIgnored, 1'b1);
    send_item(ACT_RESTART, 1'b0);
    send_item(ACT_TICK, 1'b0);
  endtask

  task automatic test_periodic();
    send_item(ACT_BEGIN, 1'b0);
    send_item(ACT_TICK, 1'b1);
    wait_until_idle();
    set_config(MODE_PERIODIC, '0, LimitReset);
    send_item(ACT_TICK, 1'b0);
  endtask

  task automatic test_toggle();
    wait_until_idle();
    set_config(MODE_TOGGLE, 32'd1, '1);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b1);
  endtask

  task automatic test_up_counter();
    wait_until_idle();
    set_config(MODE_COUNT_UP, '0, 16'd1);
    send_item(ACT_BEGIN, 1'b0);
    repeat (3) send_item(ACT_TICK, 1'b0);
  endtask

  task automatic test_down_counter();
    wait_until_idle();
    set_config(MODE_COUNT_DN, '0, '0);
    send_item(ACT_BEGIN, 1'b1);
    send_item(ACT_TICK, 1'b1);
  endtask

  task automatic test_on_delay();
    wait_until_idle();
    set_config(MODE_ON_DELAY, 32'd2, '0);
    send_item(ACT_BEGIN, 1'b0);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_TICK, 1'b1);
  endtask

  task automatic test_off_delay();
    wait_until_idle();
    set_config(MODE_OFF_DELAY, 32'd1, '0);
    send_item(ACT_BEGIN, 1'b0);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_TICK, 1'b0);
  endtask

  task automatic test_spare_modes();
    wait_until_idle();
    set_config(ModeSpare6, ElapsedMax, '1);
    send_item(ACT_BEGIN, 1'b0);
    send_item(ACT_TICK, 1'b1);
    wait_until_idle();
    write_register(CfgUnused, $urandom);
    set_config(ModeSpare7, '0, '0);
    send_item(ACT_TICK, 1'b0);
  endtask

  task automatic test_random_phases();
    logic [ModeW-1:0] mode;
    logic [ElapsedW-1:0] period;
    logic [CountW-1:0] limit;
    logic trig;
    int phase;
    int item_total;
    int pick;
    trig = 1'b0;
    for (phase = 0; phase < 30; phase++) begin
      wait_until_idle();
      steady_run = (phase >= 10 && phase < 14);
      if ($urandom_range(0, 19) == 0) begin
        mode = ModeW'($urandom_range(6, 7));
      end else begin
        mode = ModeW'($urandom_range(0, 5));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        period = '0;
      end else if (pick < 80) begin
        period = $urandom_range(1, 8);
      end else if (pick < 90) begin
        period = $urandom_range(9, 40);
      end else if (pick < 95) begin
        period = ElapsedMax;
      end else begin
        period = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        limit = '0;
      end else if (pick < 85) begin
        limit = CountW'($urandom_range(1, 6));
      end else if (pick < 93) begin
        limit = '1;
      end else begin
        limit = CountW'($urandom_range(0, 65535));
      end
      set_config(mode, period, limit);
      if ($urandom_range(0, 99) < 80) begin
        send_item(ACT_BEGIN, trig);
      end
      item_total = $urandom_range(40, 86);
      repeat (item_total) begin
        if ($urandom_range(0, 99) < 12) begin
          trig = ~trig;
        end
        pick = $urandom_range(0, 99);
        if (pick < 86) begin
          send_item(ACT_TICK, trig);
        end else if (pick < 92) begin
          send_item(ACT_BEGIN, trig);
        end else if (pick < 96) begin
          send_item(ACT_RESTART, trig);
        end else begin
          send_item(ActIgnored, trig);
        end
      end
    end
    steady_run = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_stopped_after_reset();
    test_periodic();
    test_toggle();
    test_up_counter();
    test_down_counter();
    test_on_delay();
    test_off_delay();
    test_spare_modes();
    test_random_phases();
    wait_until_idle();
    if (error_count == 0) begin
      $display("multi_mode_software_timer_core test passed");
    end else begin
      $display("multi_mode_software_timer_core test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mmst_pkg.sv
hdl/multi_mode_software_timer_core.sv
tb/sv/multi_mode_software_timer_core_test.sv
